// ===== sv/bffa_pkg.sv =====
// Shared constants, types and search helpers for the bitmap first-fit allocator.
// No dependencies; used by bffa_map and bitmap_first_fit_allocator_core.
`timescale 1ns / 1ps

package bffa_pkg;

  localparam int MAP_BITS   = 8192;
  localparam int WORD_W     = 64;
  localparam int BIT_W      = 6;
  localparam int MAP_WORDS  = (MAP_BITS + WORD_W - 1) / WORD_W;
  localparam int ADDR_W     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int NUM_GROUPS = (MAP_WORDS + 7) / 8;
  localparam int GRP_W      = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
  localparam int NUM_W      = 14;
  localparam int STATUS_W   = 2;
  // wide enough for the register, the map size and any bit index
  localparam int CMP_W      = (($clog2(MAP_BITS + 1) > NUM_W) ? $clog2(MAP_BITS + 1) : NUM_W) + 1;
  localparam int CFG_RESET  = 8192;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_ALLOC = 2'd2,
    ST_RANGE     = 2'd3
  } status_t;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] data;
  } map_wr_t;

  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] idx;
  } map_srch_t;

  function automatic logic [2:0] lowest_zero8(input logic [7:0] v);
    logic [2:0] r;
    r = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (!v[i]) r = 3'(i);
    end
    return r;
  endfunction

  // lowest clear bit of a 64-bit word: byte first, then bit within byte
  function automatic logic [BIT_W-1:0] lowest_zero64(input logic [WORD_W-1:0] w);
    logic [2:0] sel;
    logic [2:0] b;
    sel = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (w[i*8 +: 8] != 8'hFF) sel = 3'(i);
    end
    b = lowest_zero8(w[sel*8 +: 8]);
    return {sel, b};
  endfunction

endpackage

// ===== sv/bitmap_first_fit_allocator_core.sv =====
// Top level of the bitmap first-fit allocator: command stream, config register, result stream.
// Depends on bffa_pkg and bffa_map.
`timescale 1ns / 1ps

// Usage
//   s_*   : command stream. s_tuser[0] = command (0 allocate, 1 free),
//           s_tdata[13:0] = one-based entry number (ignored on allocate).
//   m_*   : result stream, one transfer per command. m_tdata[13:0] =
//           allocated number (0 on full or free), m_tdata[15:14] = status
//           (0 ok, 1 full, 2 not allocated, 3 out of range).
//   cfg_* : write of entries_in_use; always ready. Write only while idle.
// Timing
//   A command is taken in S_IDLE, the free word is found and its map
//   word read in S_FIND, and the word is modified and written back in
//   S_MOD, when the result is loaded. The result is registered into
//   m_tvalid and m_tdata on leaving S_MOD. A new command is accepted
//   only in S_IDLE, after the last one has been written back.
// Reset
//   Per-word valid and full flags clear at once, so the map reads empty
//   with no clearing pass; entries_in_use returns to 8192.
// Backpressure
//   A pending result sits in the output register while the next command
//   is accepted; that command then holds in write-back until m_tready.

module bitmap_first_fit_allocator_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [13:0] entry_number, [15:14] zero
  input  logic [0:0]  s_tuser,   // [0] command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [13:0] allocated_number, [15:14] status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [13:0] cfg_data   // [13:0] entries_in_use
);

  typedef enum logic [1:0] {S_IDLE, S_FIND, S_MOD} state_t;

  localparam int CW = bffa_pkg::CMP_W;

  state_t state;

  logic [bffa_pkg::NUM_W-1:0]  entries_in_use;
  bffa_pkg::cmd_t              cmd;
  logic [bffa_pkg::NUM_W-1:0]  num;
  logic [bffa_pkg::ADDR_W-1:0] word;
  logic [bffa_pkg::BIT_W-1:0]  bitpos;
  logic                        none_free;
  logic                        range_err;

  logic [bffa_pkg::NUM_W-1:0]  out_num;
  bffa_pkg::status_t           out_status;

  logic [CW-1:0]               limit;
  logic [CW-1:0]               free_idx;
  logic [CW-1:0]               alloc_idx;
  logic [bffa_pkg::BIT_W-1:0]  alloc_bit;
  logic                        rd_en;
  logic [bffa_pkg::ADDR_W-1:0] rd_addr;
  logic [bffa_pkg::WORD_W-1:0] rd_data;
  bffa_pkg::map_wr_t           wr;
  bffa_pkg::map_srch_t         srch;
  logic                        out_free;
  logic [bffa_pkg::NUM_W-1:0]  res_num;
  bffa_pkg::status_t           res_status;

  bffa_map u_map (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr      (wr),
    .srch    (srch)
  );

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign m_tdata   = {out_status, out_num};
  assign out_free  = !m_tvalid || m_tready;

  // usable limit saturates at the map size
  assign limit = (CW'(entries_in_use) > CW'(bffa_pkg::MAP_BITS)) ?
                 CW'(bffa_pkg::MAP_BITS) : CW'(entries_in_use);
  assign free_idx = CW'(num) - CW'(1);

  // search and read address
  always_comb begin
    rd_en   = (state == S_FIND);
    rd_addr = (cmd == bffa_pkg::CMD_ALLOC) ? srch.idx :
              bffa_pkg::ADDR_W'(free_idx >> bffa_pkg::BIT_W);
  end

  // modify and write back
  always_comb begin
    alloc_bit  = bffa_pkg::lowest_zero64(rd_data);
    alloc_idx  = (CW'(word) << bffa_pkg::BIT_W) | CW'(alloc_bit);
    wr.addr    = word;
    wr.data    = rd_data;
    wr.en      = 1'b0;
    res_num    = '0;
    res_status = bffa_pkg::ST_OK;
    if (cmd == bffa_pkg::CMD_ALLOC) begin
      if (none_free || alloc_idx >= limit) begin
        res_status = bffa_pkg::ST_FULL;
      end else begin
        wr.data = rd_data | (bffa_pkg::WORD_W'(1) << alloc_bit);
        wr.en   = 1'b1;
        res_num = bffa_pkg::NUM_W'(alloc_idx + CW'(1));
      end
    end else begin
      if (range_err) begin
        res_status = bffa_pkg::ST_RANGE;
      end else if (!rd_data[bitpos]) begin
        res_status = bffa_pkg::ST_NOT_ALLOC;
      end else begin
        wr.data = rd_data & ~(bffa_pkg::WORD_W'(1) << bitpos);
        wr.en   = 1'b1;
      end
    end
    wr.en = wr.en && (state == S_MOD) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      m_tvalid       <= 1'b0;
      entries_in_use <= bffa_pkg::NUM_W'(bffa_pkg::CFG_RESET);
    end else begin
      if (cfg_valid) begin
        entries_in_use <= cfg_data;
      end
      // in write-back a drained result is replaced by the new one below
      if (m_tvalid && m_tready && state != S_MOD) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            cmd   <= bffa_pkg::cmd_t'(s_tuser[0]);
            num   <= s_tdata[bffa_pkg::NUM_W-1:0];
            state <= S_FIND;
          end
        end
        S_FIND: begin
          none_free <= !srch.found;
          range_err <= (num == '0) || (CW'(num) > limit);
          word      <= rd_addr;
          bitpos    <= free_idx[bffa_pkg::BIT_W-1:0];
          state     <= S_MOD;
        end
        S_MOD: begin
          if (out_free) begin
            m_tvalid   <= 1'b1;
            out_num    <= res_num;
            out_status <= res_status;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/bffa_map.sv =====
// Occupancy map storage: word memory, per-word valid and full flags, free-word search.
// Depends on bffa_pkg.
`timescale 1ns / 1ps

module bffa_map (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         rd_en,
  input  logic [bffa_pkg::ADDR_W-1:0]  rd_addr,
  output logic [bffa_pkg::WORD_W-1:0]  rd_data,
  input  bffa_pkg::map_wr_t            wr,
  output bffa_pkg::map_srch_t          srch
);

  logic [bffa_pkg::WORD_W-1:0] mem [bffa_pkg::MAP_WORDS];
  logic [bffa_pkg::MAP_WORDS-1:0] valid;
  logic [bffa_pkg::MAP_WORDS-1:0] full;
  logic [bffa_pkg::WORD_W-1:0] rd_q;
  logic rd_vld;

  logic [bffa_pkg::NUM_GROUPS*8-1:0] full_pad;
  logic [bffa_pkg::NUM_GROUPS-1:0]   grp_free;
  logic [bffa_pkg::GRP_W-1:0]        gsel;
  logic [2:0]                        wsel;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // never-written words read as all free
  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      full   <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_vld <= valid[rd_addr];
      end
      if (wr.en) begin
        valid[wr.addr] <= 1'b1;
        full[wr.addr]  <= &wr.data;
      end
    end
  end

  assign rd_data = rd_vld ? rd_q : '0;

  // two-level search: lowest group with a free word, then lowest word in it
  always_comb begin
    full_pad = '1;
    full_pad[bffa_pkg::MAP_WORDS-1:0] = full;
    for (int g = 0; g < bffa_pkg::NUM_GROUPS; g++) begin
      grp_free[g] = ~&full_pad[g*8 +: 8];
    end
    gsel = '0;
    for (int g = bffa_pkg::NUM_GROUPS - 1; g >= 0; g--) begin
      if (grp_free[g]) gsel = bffa_pkg::GRP_W'(g);
    end
    wsel = bffa_pkg::lowest_zero8(full_pad[gsel*8 +: 8]);
    srch.found = |grp_free;
    srch.idx   = bffa_pkg::ADDR_W'((int'(gsel) << 3) + int'(wsel));
  end

endmodule
